>>> rtl/core/bqf_pkg.sv
// Shared constants, types and control codes of the biquad filter core.
`default_nettype none

package bqf_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int COEF_WIDTH  = 24;
    localparam int COEF_FRAC   = 20;
    localparam int STATE_WIDTH = 44;
    localparam int NUM_COEF    = 5;
    localparam int IDX_WIDTH   = $clog2(NUM_COEF);

    // second multiplier operand holds a sample, the clamped integer part of y
    // or its unsigned fraction part
    localparam int MUL_B_W = (DATA_WIDTH > COEF_FRAC) ? DATA_WIDTH : COEF_FRAC + 1;
    localparam int PROD_W  = COEF_WIDTH + MUL_B_W;
    // accumulator: state plus two full products with headroom
    localparam int ACC_W   = STATE_WIDTH + 3;
    localparam int YI_W    = ACC_W - COEF_FRAC;

    typedef logic [IDX_WIDTH-1:0] coef_idx_t;
    typedef logic [NUM_COEF-1:0][COEF_WIDTH-1:0] coef_arr_t;

    localparam coef_idx_t REG_B0 = IDX_WIDTH'(0);
    localparam coef_idx_t REG_B1 = IDX_WIDTH'(1);
    localparam coef_idx_t REG_B2 = IDX_WIDTH'(2);
    localparam coef_idx_t REG_A1 = IDX_WIDTH'(3);
    localparam coef_idx_t REG_A2 = IDX_WIDTH'(4);

    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;

    typedef enum logic [1:0] {
        MULB_X,
        MULB_YINT,
        MULB_YFRAC
    } mulb_sel_t;

    typedef enum logic [1:0] {
        ADDA_S0,
        ADDA_S1,
        ADDA_ACC,
        ADDA_ZERO
    } adda_sel_t;

    typedef enum logic {
        ADDB_P,
        ADDB_PSHR
    } addb_sel_t;

    typedef struct packed {
        coef_idx_t coef_sel;
        mulb_sel_t mulb_sel;
        adda_sel_t adda_sel;
        addb_sel_t addb_sel;
        logic      add_sub;
        logic      add_en;
        logic      to_yacc;
        logic      cap_y;
        logic      wr_s0;
        logic      wr_s1;
    } bqf_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/bqf_datapath.sv
// Shared multiplier and adder of the biquad core with the state and result registers.
`default_nettype none

module bqf_datapath (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire bqf_pkg::bqf_ctrl_t           ctrl,
    input  wire bqf_pkg::coef_arr_t           coefs,
    input  wire                               x_load,
    input  wire [bqf_pkg::DATA_WIDTH-1:0]     x_in,
    input  wire                               state_clr,
    output logic [bqf_pkg::DATA_WIDTH-1:0]    y_out,
    output logic                              clip_out
);
    import bqf_pkg::*;

    localparam logic signed [ACC_W-1:0] SMAX =
        {{(ACC_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
    localparam logic signed [YI_W-1:0] DMAX =
        {{(YI_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [YI_W-1:0] DMIN = ~DMAX;

    logic signed [DATA_WIDTH-1:0]  x_reg;
    logic signed [PROD_W-1:0]      p_reg;
    logic signed [ACC_W-1:0]       yacc_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [STATE_WIDTH-1:0] s0_reg;
    logic signed [STATE_WIDTH-1:0] s1_reg;
    logic signed [DATA_WIDTH-1:0]  yint_reg;
    logic [COEF_FRAC-1:0]          yfrac_reg;
    logic signed [DATA_WIDTH-1:0]  y_reg;
    logic                          clip_reg;

    logic signed [COEF_WIDTH-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [ACC_W-1:0]       add_a;
    logic signed [ACC_W-1:0]       add_b;
    logic signed [ACC_W-1:0]       add_sum;
    logic signed [YI_W-1:0]        yint_raw;
    logic signed [YI_W-1:0]        yrnd;
    logic                          fb_hi;
    logic                          fb_lo;
    logic                          st_hi;
    logic                          st_lo;
    logic signed [STATE_WIDTH-1:0] st_sat;

    // multiplier operands
    always_comb begin
        mul_a = $signed(coefs[ctrl.coef_sel]);
        case (ctrl.mulb_sel)
            MULB_X:     mul_b = MUL_B_W'(x_reg);
            MULB_YINT:  mul_b = MUL_B_W'(yint_reg);
            MULB_YFRAC: mul_b = $signed({{(MUL_B_W-COEF_FRAC){1'b0}}, yfrac_reg});
            default:    mul_b = '0;
        endcase
    end

    // adder operands: product as is, or dropped to state scale (floor)
    always_comb begin
        case (ctrl.adda_sel)
            ADDA_S0:   add_a = ACC_W'(s0_reg);
            ADDA_S1:   add_a = ACC_W'(s1_reg);
            ADDA_ACC:  add_a = acc_reg;
            ADDA_ZERO: add_a = '0;
            default:   add_a = '0;
        endcase
        case (ctrl.addb_sel)
            ADDB_P:    add_b = ACC_W'(p_reg);
            ADDB_PSHR: add_b = ACC_W'(p_reg >>> COEF_FRAC);
            default:   add_b = '0;
        endcase
        add_sum = ctrl.add_sub ? (add_a - add_b) : (add_a + add_b);
    end

    // output rounding and feedback clamp from the y accumulation
    always_comb begin
        yint_raw = yacc_reg[ACC_W-1:COEF_FRAC];
        yrnd     = yint_raw + $signed({{(YI_W-1){1'b0}}, yacc_reg[COEF_FRAC-1]});
        fb_hi    = yint_raw > DMAX;
        fb_lo    = yint_raw < DMIN;
    end

    // state saturation on the accumulator
    always_comb begin
        st_hi  = acc_reg > SMAX;
        st_lo  = acc_reg < SMIN;
        st_sat = st_hi ? SMAX[STATE_WIDTH-1:0] :
                 st_lo ? SMIN[STATE_WIDTH-1:0] : acc_reg[STATE_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        p_reg <= mul_a * mul_b;
        if (x_load) begin
            x_reg <= x_in;
        end
        if (ctrl.add_en) begin
            if (ctrl.to_yacc) begin
                yacc_reg <= add_sum;
            end else begin
                acc_reg <= add_sum;
            end
        end
        if (ctrl.cap_y) begin
            yint_reg  <= fb_hi ? DMAX[DATA_WIDTH-1:0] :
                         fb_lo ? DMIN[DATA_WIDTH-1:0] : yint_raw[DATA_WIDTH-1:0];
            yfrac_reg <= fb_hi ? {COEF_FRAC{1'b1}} :
                         fb_lo ? '0 : yacc_reg[COEF_FRAC-1:0];
            y_reg     <= (yrnd > DMAX) ? DMAX[DATA_WIDTH-1:0] :
                         (yrnd < DMIN) ? DMIN[DATA_WIDTH-1:0] : yrnd[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_reg   <= '0;
            s1_reg   <= '0;
            clip_reg <= 1'b0;
        end else begin
            if (state_clr) begin
                s0_reg <= '0;
                s1_reg <= '0;
            end else begin
                if (ctrl.wr_s0) begin
                    s0_reg <= st_sat;
                end
                if (ctrl.wr_s1) begin
                    s1_reg <= st_sat;
                end
            end
            if (ctrl.cap_y) begin
                clip_reg <= (yrnd > DMAX) || (yrnd < DMIN);
            end else if (ctrl.wr_s0) begin
                clip_reg <= clip_reg | st_hi | st_lo;
            end
        end
    end

    assign y_out    = y_reg;
    assign clip_out = clip_reg | st_hi | st_lo;

endmodule

`default_nettype wire

>>> rtl/core/bqf_seq.sv
// Step sequencer that drives the shared multiply-accumulate unit of the biquad core.
`default_nettype none

module bqf_seq (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       start,
    input  wire                       out_free,
    output logic                      ready,
    output logic                      emit,
    output bqf_pkg::bqf_ctrl_t        ctrl
);
    import bqf_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_MB0  = 11'b000_0000_0010,
        ST_MB1  = 11'b000_0000_0100,
        ST_YCAP = 11'b000_0000_1000,
        ST_MA1I = 11'b000_0001_0000,
        ST_MA1F = 11'b000_0010_0000,
        ST_MB2  = 11'b000_0100_0000,
        ST_MA2I = 11'b000_1000_0000,
        ST_MA2F = 11'b001_0000_0000,
        ST_ACC  = 11'b010_0000_0000,
        ST_DONE = 11'b100_0000_0000
    } seq_state_t;

    seq_state_t state_reg;
    seq_state_t state_next;

    always_comb begin
        ctrl          = '0;
        ctrl.coef_sel = REG_B0;
        ctrl.mulb_sel = MULB_X;
        ctrl.adda_sel = ADDA_ACC;
        ctrl.addb_sel = ADDB_P;
        state_next    = state_reg;
        emit          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_MB0;
                end
            end
            ST_MB0: begin
                state_next = ST_MB1;
            end
            ST_MB1: begin
                ctrl.coef_sel = REG_B1;
                ctrl.add_en   = 1'b1;
                ctrl.adda_sel = ADDA_S0;
                ctrl.to_yacc  = 1'b1;
                state_next    = ST_YCAP;
            end
            ST_YCAP: begin
                ctrl.add_en   = 1'b1;
                ctrl.adda_sel = ADDA_S1;
                ctrl.cap_y    = 1'b1;
                state_next    = ST_MA1I;
            end
            ST_MA1I: begin
                ctrl.coef_sel = REG_A1;
                ctrl.mulb_sel = MULB_YINT;
                state_next    = ST_MA1F;
            end
            ST_MA1F: begin
                ctrl.coef_sel = REG_A1;
                ctrl.mulb_sel = MULB_YFRAC;
                ctrl.add_en   = 1'b1;
                ctrl.add_sub  = 1'b1;
                state_next    = ST_MB2;
            end
            ST_MB2: begin
                ctrl.coef_sel = REG_B2;
                ctrl.add_en   = 1'b1;
                ctrl.add_sub  = 1'b1;
                ctrl.addb_sel = ADDB_PSHR;
                state_next    = ST_MA2I;
            end
            ST_MA2I: begin
                ctrl.coef_sel = REG_A2;
                ctrl.mulb_sel = MULB_YINT;
                ctrl.add_en   = 1'b1;
                ctrl.adda_sel = ADDA_ZERO;
                ctrl.wr_s0    = 1'b1;
                state_next    = ST_MA2F;
            end
            ST_MA2F: begin
                ctrl.coef_sel = REG_A2;
                ctrl.mulb_sel = MULB_YFRAC;
                ctrl.add_en   = 1'b1;
                ctrl.add_sub  = 1'b1;
                state_next    = ST_ACC;
            end
            ST_ACC: begin
                ctrl.add_en   = 1'b1;
                ctrl.add_sub  = 1'b1;
                ctrl.addb_sel = ADDB_PSHR;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    ctrl.wr_s1 = 1'b1;
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/biquad_iir_filter.sv
// Top level of the biquad IIR filter: coefficient registers, stream ports, output register.
`default_nettype none

// Second-order IIR section in transposed direct form II for signed 16-bit
// samples. Each request on the s_ side gives one result on the m_ side:
// y = b0*x + s0, rounded to nearest (ties up) and saturated to 16 bits, with
// m_tuser set when the output or either 44-bit state term saturated. The
// coefficients are signed Q3.20 and are written through the cfg_ port (index
// 0..4 = b0, b1, b2, a1, a2; other indices are ignored); any coefficient write
// clears both state terms. After reset b0 is 1.0 and the rest are 0, so the
// filter passes samples through. All seven products go through one 24x21
// multiplier and one adder under a ten-step sequencer, so s_tready stays low
// from the accepting edge until the sequencer is idle again, and a new sample
// is accepted only once the previous one has gone through every step; a
// finished result waits in the output register and a new sample is accepted
// meanwhile, but the last step holds until the previous result is taken.
// Write coefficients only while the filter is idle.
module biquad_iir_filter (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // sample input
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire [bqf_pkg::DATA_WIDTH-1:0]         s_tdata,   // [15:0] sample_in
    // filtered output
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [bqf_pkg::DATA_WIDTH-1:0]        m_tdata,   // [15:0] sample_out
    output logic                                  m_tuser,   // [0] clipped
    // coefficient writes
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [bqf_pkg::IDX_WIDTH-1:0]          cfg_index,
    input  wire [bqf_pkg::COEF_WIDTH-1:0]         cfg_data
);
    import bqf_pkg::*;

    // reset set: b0 = 1.0, every other coefficient zero
    localparam coef_arr_t COEF_RESET = coef_arr_t'(COEF_ONE) << (COEF_WIDTH * int'(REG_B0));

    coef_arr_t               coef_reg;
    logic                    m_tvalid_reg;
    logic [DATA_WIDTH-1:0]   m_tdata_reg;
    logic                    m_tuser_reg;

    logic                    s_accept;
    logic                    cfg_wr;
    logic                    out_free;
    logic                    seq_ready;
    logic                    emit;
    bqf_ctrl_t               ctrl;
    logic [DATA_WIDTH-1:0]   y_val;
    logic                    clip_val;

    assign s_accept  = s_tvalid & s_tready;
    // only the five coefficient indices take effect
    assign cfg_wr    = cfg_valid & cfg_ready & (cfg_index < IDX_WIDTH'(NUM_COEF));
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign s_tready  = seq_ready;
    assign cfg_ready = 1'b1;

    // coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= COEF_RESET;
        end else if (cfg_wr) begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    bqf_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept),
        .out_free (out_free),
        .ready    (seq_ready),
        .emit     (emit),
        .ctrl     (ctrl)
    );

    bqf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .coefs     (coef_reg),
        .x_load    (s_accept),
        .x_in      (s_tdata),
        .state_clr (cfg_wr),
        .y_out     (y_val),
        .clip_out  (clip_val)
    );

    // output register: load a finished result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= y_val;
            m_tuser_reg <= clip_val;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a result never overwrites one that has not been taken
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending result");

    // an accepted sample keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input ready while a sample is in work");

    // the output only becomes valid from a sequencer result
    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(emit))
        else $error("output valid without a result");

    // no result is produced while the sequencer is idle
    a_emit_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !seq_ready)
        else $error("result from an idle sequencer");

endmodule

`default_nettype wire

>>> tb/tb_biquad_iir_filter.sv
// Self-checking testbench for the biquad IIR filter: bit-exact prediction of every sample.
`default_nettype none

module tb_biquad_iir_filter;
    import bqf_pkg::*;

    // run shape
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_SAMPLES = 1500;
    localparam int IDLE_PCT       = 36;
    localparam int HOLD_CYCLES    = 400;

    // fixed-point ranges
    localparam longint SAMPLE_MAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint STATE_MAX  = (longint'(1) << (STATE_WIDTH - 1)) - 1;
    localparam longint STATE_MIN  = -STATE_MAX - 1;
    localparam longint FRAC_MASK  = (longint'(1) << COEF_FRAC) - 1;
    localparam longint HALF_LSB   = longint'(1) << (COEF_FRAC - 1);
    localparam int     Q_ONE      = 1 << COEF_FRAC;
    localparam int     COEF_MAX   = (1 << (COEF_WIDTH - 1)) - 1;
    localparam int     COEF_MIN   = -(1 << (COEF_WIDTH - 1));

    typedef struct packed {
        logic [DATA_WIDTH-1:0] sample;
        logic                  clipped;
    } filt_out_t;

    typedef struct packed {
        coef_idx_t             idx;
        logic [COEF_WIDTH-1:0] val;
    } coef_write_t;

    // DUT inputs start known at time zero
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [DATA_WIDTH-1:0] s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    coef_idx_t             cfg_index = REG_B0;
    logic [COEF_WIDTH-1:0] cfg_data  = '0;

    wire                   s_tready;
    wire                   m_tvalid;
    wire [DATA_WIDTH-1:0]  m_tdata;
    wire                   m_tuser;
    wire                   cfg_ready;

    // predictor state: coefficients and the two delay terms
    logic signed [COEF_WIDTH-1:0] coef_model [NUM_COEF];
    longint                       delay_s0;
    longint                       delay_s1;

    filt_out_t   pending_outputs [$];
    coef_write_t coef_batch [$];

    int          fail_count      = 0;
    int          samples_sent    = 0;
    int          results_checked = 0;
    int          coef_writes     = 0;
    int          settings_tried  = 0;
    int unsigned cycle_count     = 0;
    int unsigned hold_len        = 0;
    int unsigned hold_left       = 0;
    bit          tx_idle_on      = 1'b1;
    bit          rx_idle_on      = 1'b1;

    biquad_iir_filter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void filter_reset();
        coef_model[REG_B0] = COEF_ONE;
        coef_model[REG_B1] = '0;
        coef_model[REG_B2] = '0;
        coef_model[REG_A1] = '0;
        coef_model[REG_A2] = '0;
        delay_s0 = 0;
        delay_s1 = 0;
    endfunction

    // saturate a new delay term to its 44-bit range, flag the clip
    function automatic longint clamp_state(input longint v, inout bit hit);
        if (v > STATE_MAX) begin
            hit = 1'b1;
            return STATE_MAX;
        end
        if (v < STATE_MIN) begin
            hit = 1'b1;
            return STATE_MIN;
        end
        return v;
    endfunction

    // one transposed direct form II step; updates the delay terms
    function automatic filt_out_t filter_step(input logic signed [DATA_WIDTH-1:0] x);
        longint    xs, acc, y, yint, yfrac, t0, t1;
        longint    b0, b1, b2, a1, a2;
        bit        hit;
        filt_out_t r;
        xs  = x;
        b0  = coef_model[REG_B0];
        b1  = coef_model[REG_B1];
        b2  = coef_model[REG_B2];
        a1  = coef_model[REG_A1];
        a2  = coef_model[REG_A2];
        hit = 1'b0;

        acc = b0 * xs + delay_s0;

        // output: round half up, then saturate
        y = (acc + HALF_LSB) >>> COEF_FRAC;
        if (y > SAMPLE_MAX) begin
            y   = SAMPLE_MAX;
            hit = 1'b1;
        end else if (y < SAMPLE_MIN) begin
            y   = SAMPLE_MIN;
            hit = 1'b1;
        end

        // feedback value keeps its fraction but is clamped to the sample range
        yint  = acc >>> COEF_FRAC;
        yfrac = acc & FRAC_MASK;
        if (yint > SAMPLE_MAX) begin
            yint  = SAMPLE_MAX;
            yfrac = FRAC_MASK;
        end
        if (yint < SAMPLE_MIN) begin
            yint  = SAMPLE_MIN;
            yfrac = 0;
        end

        t0 = b1 * xs - (a1 * yint + ((a1 * yfrac) >>> COEF_FRAC)) + delay_s1;
        t1 = b2 * xs - (a2 * yint + ((a2 * yfrac) >>> COEF_FRAC));
        delay_s0 = clamp_state(t0, hit);
        delay_s1 = clamp_state(t1, hit);

        r.sample  = y[DATA_WIDTH-1:0];
        r.clipped = hit;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one sample; leave tvalid high so back-to-back requests need no gap.
    task automatic send_sample(input logic signed [DATA_WIDTH-1:0] x);
        if (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        pending_outputs.push_back(filter_step(x));
        samples_sent++;
    endtask

    // Drop tvalid, wait for every outstanding result, then let the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Issue the queued coefficient writes back to back; call only while idle.
    task automatic write_coefs();
        coef_write_t w;
        while (coef_batch.size() != 0) begin
            w = coef_batch.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.val;
            do @(posedge aclk); while (!cfg_ready);
            // a real register takes the value and clears both delays
            if (w.idx < NUM_COEF) begin
                coef_model[w.idx] = w.val;
                delay_s0 = 0;
                delay_s1 = 0;
            end
            coef_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_filter(input int b0, input int b1, input int b2,
                              input int a1, input int a2);
        coef_batch.push_back('{idx: REG_B0, val: COEF_WIDTH'(b0)});
        coef_batch.push_back('{idx: REG_B1, val: COEF_WIDTH'(b1)});
        coef_batch.push_back('{idx: REG_B2, val: COEF_WIDTH'(b2)});
        coef_batch.push_back('{idx: REG_A1, val: COEF_WIDTH'(a1)});
        coef_batch.push_back('{idx: REG_A2, val: COEF_WIDTH'(a2)});
        write_coefs();
        settings_tried++;
    endtask

    function automatic int rand_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int rand_extreme();
        case ($urandom_range(2))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            default: return 0;
        endcase
    endfunction

    // mostly full-range samples, with small values and the rails mixed in
    function automatic logic [DATA_WIDTH-1:0] rand_sample();
        int pick;
        pick = $urandom_range(19);
        if (pick < 14) return DATA_WIDTH'($urandom);
        if (pick < 17) return DATA_WIDTH'(rand_span(256));
        if (pick == 17) return DATA_WIDTH'(SAMPLE_MAX);
        if (pick == 18) return DATA_WIDTH'(SAMPLE_MIN);
        return '0;
    endfunction

    // stable section, second or first order: poles kept inside the unit circle
    task automatic set_stable(input bit first_order);
        int a1, a2, lim;
        a2  = first_order ? 0 : rand_span((Q_ONE / 20) * 19);
        lim = ((Q_ONE + a2) / 20) * 19;
        a1  = rand_span(lim);
        set_filter(rand_span(2 * Q_ONE), rand_span(2 * Q_ONE),
                   first_order ? 0 : rand_span(2 * Q_ONE), a1, a2);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset coefficients pass samples straight through; walk both rails and bit patterns.
    task automatic test_passthrough();
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(DATA_WIDTH'(SAMPLE_MAX));
        send_sample(DATA_WIDTH'(SAMPLE_MIN));
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        settle();
    endtask

    // Largest gains of either sign drive the output into saturation.
    task automatic test_output_clip();
        set_filter(COEF_MAX, 0, 0, 0, 0);
        send_sample(DATA_WIDTH'(SAMPLE_MAX));
        send_sample(DATA_WIDTH'(SAMPLE_MIN));
        send_sample(16'sd1);
        settle();
        set_filter(COEF_MIN, 0, 0, 0, 0);
        send_sample(DATA_WIDTH'(SAMPLE_MIN));
        send_sample(DATA_WIDTH'(SAMPLE_MAX));
        settle();
    endtask

    // A gain of one half puts odd samples exactly on a rounding tie.
    task automatic test_rounding_ties();
        set_filter(Q_ONE / 2, 0, 0, 0, 0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd3);
        send_sample(-16'sd3);
        settle();
    endtask

    // Strong feedback, then check that ignored indices keep the delays and
    // that a real coefficient write clears them.
    task automatic test_feedback_and_writes();
        set_filter(Q_ONE / 4, Q_ONE / 2, Q_ONE / 4, -(Q_ONE / 2) * 3, (Q_ONE / 10) * 7);
        send_sample(DATA_WIDTH'(SAMPLE_MAX));
        send_sample(DATA_WIDTH'(SAMPLE_MAX));
        send_sample(DATA_WIDTH'(SAMPLE_MAX));
        send_sample(DATA_WIDTH'(SAMPLE_MIN));
        send_sample(16'sd1000);
        settle();
        for (int i = NUM_COEF; i < (1 << IDX_WIDTH); i++)
            coef_batch.push_back('{idx: coef_idx_t'(i), val: COEF_WIDTH'($urandom)});
        write_coefs();
        send_sample(16'sd0);
        send_sample(16'sd0);
        send_sample(-16'sd500);
        settle();
        coef_batch.push_back('{idx: REG_B2, val: COEF_WIDTH'(Q_ONE / 4)});
        write_coefs();
        send_sample(16'sd0);
        send_sample(16'sd700);
        settle();
    endtask

    // Hold the result side off for a long stretch while requests keep coming,
    // so the filter fills up and stalls its input.
    task automatic test_backpressure();
        set_stable(1'b0);
        tx_idle_on = 1'b0;
        hold_len   = HOLD_CYCLES;
        repeat (24) send_sample(rand_sample());
        settle();
        tx_idle_on = 1'b1;
    endtask

    // Random phases, each with its own coefficient set; one long phase runs
    // without idling on either side.
    task automatic test_random();
        int sent, phase, n, picks;
        bit quiet;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_SAMPLES) begin
            settle();
            case ($urandom_range(5))
                0: set_filter(int'($urandom_range(0, COEF_MAX)) - int'($urandom_range(0, COEF_MAX)),
                              rand_span(COEF_MAX), rand_span(COEF_MAX),
                              rand_span(COEF_MAX), rand_span(COEF_MAX));
                1, 2: set_stable(1'b0);
                3: set_stable(1'b1);
                4: set_filter(rand_extreme(), rand_extreme(), rand_extreme(),
                              rand_extreme(), rand_extreme());
                default: begin
                    // partial reprogram, ignored indices included
                    picks = $urandom_range(1, 3);
                    repeat (picks)
                        coef_batch.push_back('{idx: coef_idx_t'($urandom_range(0, (1 << IDX_WIDTH) - 1)),
                                               val: COEF_WIDTH'($urandom)});
                    write_coefs();
                    settings_tried++;
                end
            endcase
            quiet      = (phase == 3);
            tx_idle_on = !quiet;
            rx_idle_on = !quiet;
            n          = quiet ? 250 : int'($urandom_range(40, 160));
            repeat (n) send_sample(rand_sample());
            sent += n;
            phase++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side: random tready, long hold-off on request, in-order compare
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : result_side
        filt_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected result: sample_out %0d clipped %0b", $signed(m_tdata), m_tuser);
                fail_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (m_tdata !== want.sample) begin
                    $error("sample_out mismatch: expected %0d, got %0d",
                           $signed(want.sample), $signed(m_tdata));
                    fail_count++;
                end
                if (m_tuser !== want.clipped) begin
                    $error("clipped mismatch: expected %0b, got %0b", want.clipped, m_tuser);
                    fail_count++;
                end
                results_checked++;
            end
        end
        // pick up a hold-off request and count it down here
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // hard stop if the run hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        filter_reset();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_output_clip();
        test_rounding_ties();
        test_feedback_and_writes();
        test_backpressure();
        test_random();
        settle();

        $display("Ran %0d samples through %0d coefficient settings (%0d register writes),",
                 samples_sent, settings_tried, coef_writes);
        $display("with rails, rounding ties, ignored indices and a long output stall; %0d results checked.",
                 results_checked);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
